// ===== hw/rtl/rlsc_pkg.sv =====
// Shared constants, register indexes and width helpers for the lens shading corrector.
package rlsc_pkg;

	// Port widths fixed by the interface
	localparam int PIXEL_W   = 32;
	localparam int COORD_W   = 13;
	localparam int REG_W     = 14;
	localparam int CFG_IDX_W = 2;

	// Parameter defaults
	localparam int COORD_BITS_DEF = 13;
	localparam int PIXEL_BITS_DEF = 32;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Register reset values
	localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
	localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

	// Gain scaling: 1000 is unity, the radial term spans 300
	localparam int GAIN_UNITY  = 1000;
	localparam int GAIN_SPAN   = 300;
	localparam int GAIN_FRAC_W = 10;   // bits that hold GAIN_UNITY - 1
	localparam int SPAN_W      = 9;    // bits that hold GAIN_SPAN

	// Denominator w^2 + h^2
	localparam int DEN_BITS = 2 * REG_W + 1;

	// Width of |2c - size| for a coordinate of xb bits
	function automatic int dist_bits(input int xb);
		return (xb + 1 > REG_W) ? xb + 1 : REG_W;
	endfunction

	// Width of GAIN_SPAN * (dx^2 + dy^2), also the divider quotient width
	function automatic int quo_bits(input int xb);
		return 2 * dist_bits(xb) + 1 + SPAN_W;
	endfunction

endpackage

// ===== hw/rtl/rlsc_div_pipe.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage, with side data.
module rlsc_div_pipe
	import rlsc_pkg::*;
#(
	parameter int N_BITS    = 38,
	parameter int D_BITS    = 29,
	parameter int STEPS     = 1,
	parameter int SIDE_BITS = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [N_BITS-1:0]    dividend,
	input  logic [D_BITS-1:0]    divisor,
	input  logic [SIDE_BITS-1:0] side_in,
	output logic                 out_valid,
	output logic [N_BITS-1:0]    quotient,
	output logic [SIDE_BITS-1:0] side_out
);

	localparam int STAGES = (N_BITS + STEPS - 1) / STEPS;
	localparam int TOT    = STAGES * STEPS;

	// Per-stage registers: remainder, shifting dividend/quotient word, divisor, side data
	logic                 v_s    [STAGES];
	logic [D_BITS-1:0]    rem_s  [STAGES];
	logic [TOT-1:0]       work_s [STAGES];
	logic [D_BITS-1:0]    dvs_s  [STAGES];
	logic [SIDE_BITS-1:0] side_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic                 v_i;
		logic [D_BITS-1:0]    rem_i;
		logic [TOT-1:0]       work_i;
		logic [D_BITS-1:0]    dvs_i;
		logic [SIDE_BITS-1:0] side_i;
		logic [D_BITS-1:0]    rem_n;
		logic [TOT-1:0]       work_n;

		// Stage input: the ports for the first stage, the previous stage otherwise
		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign work_i = TOT'(dividend);
			assign dvs_i  = divisor;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign work_i = work_s[g-1];
			assign dvs_i  = dvs_s[g-1];
			assign side_i = side_s[g-1];
		end

		// Shift in one dividend bit, trial subtract, shift in one quotient bit
		always_comb begin : step
			logic [D_BITS:0]   r;
			logic [D_BITS-1:0] rm;
			logic [TOT-1:0]    wk;
			rm = rem_i;
			wk = work_i;
			for (int j = 0; j < STEPS; j++) begin
				r  = {rm, wk[TOT-1]};
				wk = {wk[TOT-2:0], 1'b0};
				if (r >= {1'b0, dvs_i}) begin
					rm    = D_BITS'(r - {1'b0, dvs_i});
					wk[0] = 1'b1;
				end else begin
					rm = r[D_BITS-1:0];
				end
			end
			rem_n  = rm;
			work_n = wk;
		end

		// Valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else begin
				v_s[g] <= v_i;
			end
		end

		// Payload
		always_ff @(posedge clk) begin
			rem_s[g]  <= rem_n;
			work_s[g] <= work_n;
			dvs_s[g]  <= dvs_i;
			side_s[g] <= side_i;
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign quotient  = work_s[STAGES-1][N_BITS-1:0];
	assign side_out  = side_s[STAGES-1];

endmodule

// ===== hw/rtl/rlsc_front.sv =====
// Radial distance front end: squared half-pixel distances, w^2 + h^2 and the scaled numerator.
module rlsc_front
	import rlsc_pkg::*;
#(
	parameter int XB = COORD_BITS_DEF,
	parameter int P  = PIXEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [P-1:0]              pix,
	input  logic [XB-1:0]             x,
	input  logic [XB-1:0]             y,
	input  logic [REG_W-1:0]          w,
	input  logic [REG_W-1:0]          h,
	output logic                      out_valid,
	output logic [quo_bits(XB)-1:0]   num_scaled,
	output logic [DEN_BITS-1:0]       den,
	output logic                      den_zero,
	output logic [P-1:0]              pix_out
);

	localparam int DB    = dist_bits(XB);
	localparam int SQ_W  = 2 * DB;
	localparam int NUM_W = SQ_W + 1;
	localparam int Q_W   = quo_bits(XB);
	localparam int WW_W  = 2 * REG_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [P-1:0]       pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6;
	logic [XB-1:0]      x_s1, y_s1;
	logic [REG_W-1:0]   w_s1, h_s1, h_s2;
	logic [DB-1:0]      dx_s2, dy_s2, dy_s3;
	logic [WW_W-1:0]    ww_s2, ww_s3, hh_s3;
	logic [SQ_W-1:0]    sqx_s3, sqx_s4, sqy_s4;
	logic [DEN_BITS-1:0] den_s4, den_s5, den_s6;
	logic [NUM_W-1:0]   num_s5;
	logic               dz_s5, dz_s6;
	logic [Q_W-1:0]     n300_s6;

	// |2c - size| in half-pixel units
	function automatic logic [DB-1:0] half_dist(input logic [XB-1:0] c,
		input logic [REG_W-1:0] size);
		logic [DB:0] tc;
		logic [DB:0] sz;
		tc = (DB + 1)'({c, 1'b0});
		sz = (DB + 1)'(size);
		return (tc >= sz) ? DB'(tc - sz) : DB'(sz - tc);
	endfunction

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		// s1: capture the item and the frame size
		pix_s1 <= pix;
		x_s1   <= x;
		y_s1   <= y;
		w_s1   <= w;
		h_s1   <= h;
		// s2: distances, w^2
		pix_s2 <= pix_s1;
		dx_s2  <= half_dist(x_s1, w_s1);
		dy_s2  <= half_dist(y_s1, h_s1);
		ww_s2  <= WW_W'(w_s1) * WW_W'(w_s1);
		h_s2   <= h_s1;
		// s3: dx^2, h^2
		pix_s3 <= pix_s2;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		hh_s3  <= WW_W'(h_s2) * WW_W'(h_s2);
		ww_s3  <= ww_s2;
		dy_s3  <= dy_s2;
		// s4: dy^2, denominator
		pix_s4 <= pix_s3;
		sqy_s4 <= SQ_W'(dy_s3) * SQ_W'(dy_s3);
		den_s4 <= DEN_BITS'(ww_s3) + DEN_BITS'(hh_s3);
		sqx_s4 <= sqx_s3;
		// s5: numerator, zero-frame flag
		pix_s5 <= pix_s4;
		num_s5 <= NUM_W'(sqx_s4) + NUM_W'(sqy_s4);
		den_s5 <= den_s4;
		dz_s5  <= (den_s4 == '0);
		// s6: times 300 as 256 + 32 + 8 + 4
		pix_s6  <= pix_s5;
		n300_s6 <= (Q_W'(num_s5) << 8) + (Q_W'(num_s5) << 5)
			+ (Q_W'(num_s5) << 3) + (Q_W'(num_s5) << 2);
		den_s6  <= den_s5;
		dz_s6   <= dz_s5;
	end

	assign out_valid  = v_s6;
	assign num_scaled = n300_s6;
	assign den        = den_s6;
	assign den_zero   = dz_s6;
	assign pix_out    = pix_s6;

endmodule

// ===== hw/rtl/rlsc_scale.sv =====
// Gain application: clamp, split multiply, saturation check and divide by unity gain.
module rlsc_scale
	import rlsc_pkg::*;
#(
	parameter int P   = PIXEL_BITS_DEF,
	parameter int Q_W = quo_bits(COORD_BITS_DEF)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [Q_W-1:0] quo,
	input  logic           den_zero,
	input  logic [P-1:0]   pix,
	output logic           out_valid,
	output logic [P-1:0]   res,
	output logic           sat
);

	localparam int G_BITS = P + GAIN_FRAC_W;
	localparam int GW     = ((Q_W > G_BITS) ? Q_W : G_BITS) + 1;
	localparam int GL     = (G_BITS + 1) / 2;
	localparam int GH     = G_BITS - GL;
	localparam int PR_W   = P + G_BITS;
	localparam int DV_W   = P + GAIN_FRAC_W;

	// Divide by 1000 as a shift by 3 and a reciprocal multiply for 125
	localparam int UNITY_SH  = 3;
	localparam int UNITY_ODD = GAIN_UNITY / 8;
	localparam int M_W       = DV_W - UNITY_SH;
	localparam int RCP_SH    = P + 14;
	localparam int RCP_W     = P + 8;
	localparam int SL        = RCP_W / 2;
	localparam int MH_W      = M_W - SL;
	localparam int RH_W      = RCP_W - SL;
	localparam int HH_W      = MH_W + RH_W;
	localparam int MID_W     = RCP_W + 1;
	localparam int FP_W      = M_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((64'd1 << RCP_SH) + 64'(UNITY_ODD) - 64'd1) / 64'(UNITY_ODD));

	// Any nonzero pixel saturates at or above this gain
	localparam logic [GW-1:0]   G_CAP   = GW'(GAIN_UNITY) << P;
	localparam logic [PR_W-1:0] SAT_LIM = PR_W'(GAIN_UNITY) << P;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [P-1:0]      pix_s1, pix_s2;
	logic [G_BITS-1:0] g_s1;
	logic [GH-1:0]     ghi_s2;
	logic [P+GL-1:0]   plo_s2, plo_s3;
	logic [P+GH-1:0]   phi_s3;
	logic [PR_W-1:0]   prod_s4;
	logic              sat_s5, sat_s6, sat_s7, sat_s8;
	logic [M_W-1:0]    m_s5;
	logic [2*SL-1:0]   pll_s6, pll_s7;
	logic [RCP_W-1:0]  plh_s6;
	logic [M_W-1:0]    phl_s6;
	logic [HH_W-1:0]   phh_s6, phh_s7;
	logic [MID_W-1:0]  mid_s7;
	logic [P-1:0]      quo_s8;

	logic [GW-1:0]     gain;
	logic [FP_W-1:0]   fp_sum;

	// Gain, forced to unity for a zero-size frame
	always_comb begin
		gain = den_zero ? GW'(GAIN_UNITY) : GW'(GAIN_UNITY) + GW'(quo);
	end

	// Reciprocal product from its partial sums
	always_comb begin
		fp_sum = FP_W'(pll_s7) + (FP_W'(mid_s7) << SL) + (FP_W'(phh_s7) << (2 * SL));
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		// s1: clamped gain
		pix_s1 <= pix;
		g_s1   <= (gain >= G_CAP) ? G_CAP[G_BITS-1:0] : gain[G_BITS-1:0];
		// s2: low partial product
		pix_s2 <= pix_s1;
		ghi_s2 <= g_s1[G_BITS-1:GL];
		plo_s2 <= (P + GL)'(pix_s1) * (P + GL)'(g_s1[GL-1:0]);
		// s3: high partial product
		plo_s3 <= plo_s2;
		phi_s3 <= (P + GH)'(pix_s2) * (P + GH)'(ghi_s2);
		// s4: full product
		prod_s4 <= PR_W'(plo_s3) + (PR_W'(phi_s3) << GL);
		// s5: saturation test on the exact product, product over 8
		sat_s5 <= (prod_s4 >= SAT_LIM);
		m_s5   <= (prod_s4 >= SAT_LIM) ? '0 : prod_s4[DV_W-1:UNITY_SH];
		// s6: partial products with the reciprocal of 125
		sat_s6 <= sat_s5;
		pll_s6 <= (2 * SL)'(m_s5[SL-1:0]) * (2 * SL)'(RCP[SL-1:0]);
		plh_s6 <= RCP_W'(m_s5[SL-1:0]) * RCP_W'(RCP[RCP_W-1:SL]);
		phl_s6 <= M_W'(m_s5[M_W-1:SL]) * M_W'(RCP[SL-1:0]);
		phh_s6 <= HH_W'(m_s5[M_W-1:SL]) * HH_W'(RCP[RCP_W-1:SL]);
		// s7: middle terms
		sat_s7 <= sat_s6;
		pll_s7 <= pll_s6;
		phh_s7 <= phh_s6;
		mid_s7 <= MID_W'(plh_s6) + MID_W'(phl_s6);
		// s8: quotient
		sat_s8 <= sat_s7;
		quo_s8 <= fp_sum[RCP_SH +: P];
	end

	assign out_valid = v_s8;
	assign res       = sat_s8 ? '1 : quo_s8;
	assign sat       = sat_s8;

endmodule

// ===== hw/rtl/radial_lens_shading_correction.sv =====
// Top level of the radial lens shading corrector: registers, pipeline and result port.
//
// Radial lens shading correction. Each start transaction carries one pixel with its column
// and row; exactly one result comes out on pixel_out/saturated, marked by a one-cycle done
// strobe, once the pixel has passed the front end, the gain divider, the scale pipeline and
// the result register. busy is never raised, so one pixel is taken every clock; the main
// divider is a restoring divider with one quotient bit per stage. Results cannot be held off
// and must be taken on the done cycle. The gain is 1000 + floor(300 * ((2x-w)^2 + (2y-h)^2) /
// (w^2 + h^2)) in thousandths, unity when w and h are both zero; the output is
// floor(pixel * gain / 1000), clipped to 2^PIXEL_BITS - 1 with saturated set. frame_width
// (index 0) and frame_height (index 1) are written through the cfg channel, which is always
// ready; write them only while no pixel is in flight. Other indexes are ignored.
module radial_lens_shading_correction
	import rlsc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel command
	input  logic                 start,
	output logic                 busy,
	input  logic [PIXEL_W-1:0]   pixel_in,
	input  logic [COORD_W-1:0]   column,
	input  logic [COORD_W-1:0]   row,
	// result
	output logic                 done,
	output logic [PIXEL_W-1:0]   pixel_out,
	output logic                 saturated,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	localparam int XB  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int P   = PIXEL_BITS;
	localparam int Q_W = quo_bits(XB);

	logic [REG_W-1:0] frame_width_q, frame_height_q;

	logic                front_valid;
	logic [Q_W-1:0]      num_scaled;
	logic [DEN_BITS-1:0] den;
	logic                den_zero;
	logic [P-1:0]        front_pix;

	logic                div_valid;
	logic [Q_W-1:0]      quo;
	logic [P:0]          div_side;

	logic                scale_valid;
	logic [P-1:0]        scale_res;
	logic                scale_sat;

	logic                done_q;
	logic [P-1:0]        pixel_out_q;
	logic                saturated_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Frame size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Distances and numerator
	rlsc_front #(
		.XB(XB),
		.P (P)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pix       (pixel_in[P-1:0]),
		.x         (column[XB-1:0]),
		.y         (row[XB-1:0]),
		.w         (frame_width_q),
		.h         (frame_height_q),
		.out_valid (front_valid),
		.num_scaled(num_scaled),
		.den       (den),
		.den_zero  (den_zero),
		.pix_out   (front_pix)
	);

	// Radial term: 300 * num / den
	rlsc_div_pipe #(
		.N_BITS   (Q_W),
		.D_BITS   (DEN_BITS),
		.STEPS    (1),
		.SIDE_BITS(P + 1)
	) u_gain_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.dividend (num_scaled),
		.divisor  (den),
		.side_in  ({den_zero, front_pix}),
		.out_valid(div_valid),
		.quotient (quo),
		.side_out (div_side)
	);

	// Apply gain
	rlsc_scale #(
		.P  (P),
		.Q_W(Q_W)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.quo      (quo),
		.den_zero (div_side[P]),
		.pix      (div_side[P-1:0]),
		.out_valid(scale_valid),
		.res      (scale_res),
		.sat      (scale_sat)
	);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= scale_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		pixel_out_q <= scale_res;
		saturated_q <= scale_sat;
	end

	assign done      = done_q;
	assign pixel_out = PIXEL_W'(pixel_out_q);
	assign saturated = saturated_q;

endmodule
